[hdl/rfopp_pkg.sv]
package rfopp_pkg;

  localparam int LEVEL_W    = 16;
  localparam int STEP_W     = 14;
  localparam int GAIN_W     = 15;
  localparam int ATT_W      = 16;
  localparam int ACTUAL_W   = 18;
  localparam int NET_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STAGES = ATT_W;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [STEP_W-1:0] ATTEN_STEP_RESET = STEP_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL0      = 3'd0,
    REG_LEVEL1      = 3'd1,
    REG_LEVEL2      = 3'd2,
    REG_LEVEL3      = 3'd3,
    REG_ATTEN_STEP  = 3'd4,
    REG_BUFFER_GAIN = 3'd5,
    REG_ATTEN_MAX   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level0;
    logic signed [LEVEL_W-1:0] level1;
    logic signed [LEVEL_W-1:0] level2;
    logic signed [LEVEL_W-1:0] level3;
    logic        [STEP_W-1:0]  atten_step;
    logic signed [GAIN_W-1:0]  buffer_gain;
    logic signed [GAIN_W-1:0]  atten_max;
  } cfg_t;

  // classified set point handed from front to back
  typedef struct packed {
    logic                    err;
    logic [1:0]              sel;
    logic                    en;
    logic signed [NET_W-1:0] lvl_net;
    logic [ATT_W-1:0]        diff;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[hdl/rfopp_front.sv]
module rfopp_front
  import rfopp_pkg::*;
(
  input  cfg_t                      cfg,
  input  logic signed [LEVEL_W-1:0] set_point,
  output entry_t                    entry
);

  logic                      bad_cfg;
  logic signed [NET_W-1:0]   a_ext;
  logic signed [NET_W-1:0]   thr_off;
  logic signed [NET_W-1:0]   deduct;
  logic signed [NET_W-1:0]   thr0;
  logic signed [NET_W-1:0]   thr1;
  logic signed [NET_W-1:0]   thr2;
  logic signed [LEVEL_W-1:0] level;
  logic [1:0]                sel;
  logic                      en;
  logic signed [NET_W-1:0]   lvl_net;
  logic signed [NET_W:0]     diff_w;

  always_comb begin
    bad_cfg = (cfg.level0 > cfg.level1) || (cfg.level1 > cfg.level2) ||
              (cfg.level2 > cfg.level3) || (cfg.atten_step == '0) ||
              cfg.buffer_gain[GAIN_W-1] || cfg.atten_max[GAIN_W-1];

    a_ext   = NET_W'(set_point);
    thr_off = NET_W'(cfg.level0) - NET_W'(cfg.atten_max);
    en      = !(a_ext < thr_off);
    deduct  = en ? '0 : NET_W'(cfg.buffer_gain);

    thr0 = NET_W'(cfg.level0) - deduct;
    thr1 = NET_W'(cfg.level1) - deduct;
    thr2 = NET_W'(cfg.level2) - deduct;

    if (a_ext > thr2) begin
      sel   = 2'd3;
      level = cfg.level3;
    end else if (a_ext > thr1) begin
      sel   = 2'd2;
      level = cfg.level2;
    end else if (a_ext > thr0) begin
      sel   = 2'd1;
      level = cfg.level1;
    end else begin
      sel   = 2'd0;
      level = cfg.level0;
    end

    lvl_net = NET_W'(level) - deduct;
    diff_w  = (NET_W+1)'(lvl_net) - (NET_W+1)'(set_point);

    entry.err     = bad_cfg;
    entry.sel     = sel;
    entry.en      = en;
    entry.lvl_net = lvl_net;
    // negative difference clamps to zero, top of range is 65535
    entry.diff    = diff_w[NET_W] ? '0 : diff_w[ATT_W-1:0];
  end

endmodule

[hdl/rfopp_queue.sv]
module rfopp_queue
  import rfopp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  entry_t      wr_entry,
  input  logic        pop,
  output entry_t      rd_entry,
  output queue_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_entry   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/rfopp_back.sv]
module rfopp_back
  import rfopp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  entry_t                     q_entry,
  input  queue_stat_t                q_stat,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       config_error,
  output logic [1:0]                 level_select,
  output logic [ATT_W-1:0]           attenuation,
  output logic                       buffer_enable,
  output logic signed [ACTUAL_W-1:0] actual_power
);

  typedef struct packed {
    logic                    valid;
    logic                    err;
    logic [1:0]              sel;
    logic                    en;
    logic signed [NET_W-1:0] lvl_net;
    logic [ATT_W-1:0]        diff;
    logic [STEP_W-1:0]       rem;
  } stage_t;

  typedef struct packed {
    logic                    valid;
    logic                    err;
    logic [1:0]              sel;
    logic                    en;
    logic signed [NET_W-1:0] lvl_net;
    logic [ATT_W-1:0]        att;
  } fin_t;

  stage_t          stg      [DIV_STAGES+1];
  stage_t          stg_next [DIV_STAGES+1];
  fin_t            fin;
  fin_t            fin_next;
  logic            adv;
  logic [ATT_W:0]  att_up;
  stage_t          last;

  // the whole pipeline moves unless the output register is held
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_stat.empty;
  assign last  = stg[DIV_STAGES];

  // restoring remainder, one quotient bit per stage, msb first
  always_comb begin
    logic [STEP_W:0] rem_sh;
    stg_next[0]         = '0;
    stg_next[0].valid   = q_pop;
    stg_next[0].err     = q_entry.err;
    stg_next[0].sel     = q_entry.sel;
    stg_next[0].en      = q_entry.en;
    stg_next[0].lvl_net = q_entry.lvl_net;
    stg_next[0].diff    = q_entry.diff;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      stg_next[k] = stg[k-1];
      rem_sh = {stg[k-1].rem, stg[k-1].diff[DIV_STAGES-k]};
      if (rem_sh >= {1'b0, cfg.atten_step}) begin
        rem_sh = rem_sh - {1'b0, cfg.atten_step};
      end
      stg_next[k].rem = rem_sh[STEP_W-1:0];
    end
  end

  // round up to a whole step, back off one step if it leaves 16 bits
  always_comb begin
    if (last.rem == '0) begin
      att_up = {1'b0, last.diff};
    end else begin
      att_up = {1'b0, last.diff} - (ATT_W+1)'(last.rem) + (ATT_W+1)'(cfg.atten_step);
    end
    if (att_up[ATT_W]) begin
      att_up = att_up - (ATT_W+1)'(cfg.atten_step);
    end
    fin_next.valid   = last.valid;
    fin_next.err     = last.err;
    fin_next.sel     = last.sel;
    fin_next.en      = last.en;
    fin_next.lvl_net = last.lvl_net;
    fin_next.att     = att_up[ATT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        stg[k].valid <= 1'b0;
      end
      fin.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        stg[k] <= stg_next[k];
      end
      fin       <= fin_next;
      out_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      config_error <= fin.err;
      if (fin.err) begin
        level_select  <= '0;
        attenuation   <= '0;
        buffer_enable <= 1'b0;
        actual_power  <= '0;
      end else begin
        level_select  <= fin.sel;
        attenuation   <= fin.att;
        buffer_enable <= fin.en;
        actual_power  <= ACTUAL_W'(fin.lvl_net) - ACTUAL_W'({2'b00, fin.att});
      end
    end
  end

endmodule

[hdl/rf_output_power_planner.sv]
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// input    | in_valid/in_stall  | set_point
// output   | out_valid/out_stall| config_error level_select attenuation
//          |                    | buffer_enable actual_power
// config   | cfg_valid/cfg_ready| cfg_index cfg_data
//
// one set point per cycle is taken while the queue is not full, results leave one per cycle while not stalled
// path: queue, input stage, 16 stage remainder pipeline, rounding, output
// rst is synchronous: queue empties, pipeline valids clear, config registers take reset values
// out_stall with out_valid high freezes the back pipeline; the queue keeps taking input until it is full
module rf_output_power_planner
  import rfopp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [LEVEL_W-1:0]  set_point,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       config_error,
  output logic [1:0]                 level_select,
  output logic [ATT_W-1:0]           attenuation,
  output logic                       buffer_enable,
  output logic signed [ACTUAL_W-1:0] actual_power,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  cfg_t        cfg;
  entry_t      f_entry;
  entry_t      q_entry;
  queue_stat_t q_stat;
  logic        q_pop;
  logic        push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level0      <= '0;
      cfg.level1      <= '0;
      cfg.level2      <= '0;
      cfg.level3      <= '0;
      cfg.atten_step  <= ATTEN_STEP_RESET;
      cfg.buffer_gain <= '0;
      cfg.atten_max   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEVEL0:      cfg.level0      <= cfg_data;
        REG_LEVEL1:      cfg.level1      <= cfg_data;
        REG_LEVEL2:      cfg.level2      <= cfg_data;
        REG_LEVEL3:      cfg.level3      <= cfg_data;
        REG_ATTEN_STEP:  cfg.atten_step  <= cfg_data[STEP_W-1:0];
        REG_BUFFER_GAIN: cfg.buffer_gain <= cfg_data[GAIN_W-1:0];
        REG_ATTEN_MAX:   cfg.atten_max   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !in_stall;

  rfopp_front u_front (
    .cfg       (cfg),
    .set_point (set_point),
    .entry     (f_entry)
  );

  rfopp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (f_entry),
    .pop      (q_pop),
    .rd_entry (q_entry),
    .stat     (q_stat)
  );

  rfopp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_entry       (q_entry),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .config_error  (config_error),
    .level_select  (level_select),
    .attenuation   (attenuation),
    .buffer_enable (buffer_enable),
    .actual_power  (actual_power)
  );

  a_err_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && config_error |-> level_select == '0 && attenuation == '0 &&
    !buffer_enable && actual_power == '0)
    else $error("config error result carries nonzero fields");

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && q_stat.empty)
    else $error("reset left a transaction pending");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !q_pop)
    else $error("pop from empty queue");

endmodule
